### rtl/pat_pkg.sv
// Shared types and constants for the pending acknowledgement tracker.
package pat_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int MASK_BITS   = 8;

    localparam logic [31:0] TIMEOUT_RESET = 32'd120000;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_POLL = 2'd2;

    localparam logic [1:0] CAUSE_REPLY   = 2'd0;
    localparam logic [1:0] CAUSE_EVICT   = 2'd1;
    localparam logic [1:0] CAUSE_RETRY   = 2'd2;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN,
        ST_FLUSH
    } t_state;

endpackage

### rtl/pending_ack_tracker.sv
// Pending acknowledgement tracker: entry table walked by a single sequencer.
//
// Usage: commands arrive on the input channel (i_in_valid / o_in_stall) and
// outcome reports leave on the output channel (o_out_valid / i_out_stall).
// An add stores a packet id and time in a free entry, or evicts the oldest
// entry and reports it. An ack/nak finalises the first matching entry and
// reports it. A poll frees finalised entries and reports entries whose
// retries stopped or whose age reached the timeout (at most eight reports).
// o_last marks the final report caused by one command.
// Each item is taken in, then walked one table entry at a time through the
// shared compare unit; an add is then written back and the final report is
// handed over. Reports are held one behind the walk so that o_last is
// known when they are sent. A stalled receiver holds the walk on the next
// report; o_in_stall stays high until the item is finished. The timeout
// register is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while the block is idle, which the block itself does not
// enforce. Reset (synchronous, active low) empties the table at once and
// sets the timeout to 120000 ms; there is no clearing pass.
module pending_ack_tracker
    import pat_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_packet_id,
    input  logic        i_is_ack,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_awaiting_mask,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_packet_id_out,
    output logic        o_delivered,
    output logic [1:0]  o_cause,
    output logic        o_last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_state r_state, n_state;

    logic [31:0] r_timeout;

    logic [ENTRIES-1:0] r_valid, r_seen, r_fin;
    logic [31:0]        r_eid   [ENTRIES];
    logic [31:0]        r_etime [ENTRIES];

    logic [1:0]  r_cmd;
    logic [31:0] r_id;
    logic        r_ack;
    logic [31:0] r_now;
    logic [7:0]  r_mask;

    logic [IW-1:0] r_idx;
    logic          r_hit;
    logic          r_free_v;
    logic [IW-1:0] r_tgt;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_time;
    logic [31:0]   r_best_id;

    logic             r_pend_v;
    logic [31:0]      r_pend_id;
    logic             r_pend_del;
    logic [1:0]       r_pend_cause;
    logic [CNT_W-1:0] r_cnt;

    logic        r_ovalid;
    logic [31:0] r_oid;
    logic        r_odel;
    logic [1:0]  r_ocause;
    logic        r_olast;

    logic        in_acc;
    logic        out_free;
    logic        cur_valid, cur_fin, cur_seen;
    logic [31:0] cur_id, cur_time;
    logic [31:0] age;
    logic        timed_out, earlier, busy;
    logic        poll_ev, ack_ev;
    logic        hit_emit, can_rep, walk_hold, step;
    logic        push_mid, push_last, out_load;
    logic        last_idx;
    logic [1:0]  hit_cause;
    logic        hit_del;
    logic [IW-1:0] add_tgt;

    // Entry under the walk pointer, and the shared compare unit
    always_comb begin
        cur_valid = r_valid[r_idx];
        cur_fin   = r_fin[r_idx];
        cur_seen  = r_seen[r_idx];
        cur_id    = r_eid[r_idx];
        cur_time  = r_etime[r_idx];
        age       = r_now - cur_time;
        timed_out = (age >= r_timeout);
        earlier   = (cur_time < r_best_time);
        busy      = (32'(r_idx) < MASK_BITS) && r_mask[3'(r_idx)];
        last_idx  = (r_idx == IW'(ENTRIES - 1));
    end

    always_comb begin
        poll_ev = (r_cmd == CMD_POLL) && cur_valid && !cur_fin
                  && ((!busy && cur_seen) || timed_out);
        ack_ev  = (r_cmd == CMD_ACK) && (r_id != 32'd0) && !r_hit
                  && cur_valid && (cur_id == r_id);
        if (r_cmd == CMD_ACK) begin
            hit_cause = CAUSE_REPLY;
            hit_del   = r_ack;
        end else begin
            hit_cause = (!busy && cur_seen) ? CAUSE_RETRY : CAUSE_TIMEOUT;
            hit_del   = 1'b0;
        end
    end

    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        out_free  = !r_ovalid || !i_out_stall;
        hit_emit  = (r_state == ST_WALK) && (poll_ev || ack_ev);
        can_rep   = (r_cnt < CNT_W'(MAX_RESULTS));
        // a new report pushes the held one out; wait if the output is blocked
        walk_hold = hit_emit && can_rep && r_pend_v && !out_free;
        step      = (r_state == ST_WALK) && !walk_hold;
        push_mid  = step && hit_emit && can_rep && r_pend_v;
        push_last = (r_state == ST_FLUSH) && r_pend_v && out_free;
        out_load  = push_mid || push_last;
        add_tgt   = r_free_v ? r_tgt : r_best_idx;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_WALK;
            ST_WALK:  if (step && last_idx) n_state = ST_FIN;
            ST_FIN:   n_state = ST_FLUSH;
            ST_FLUSH: if (!r_pend_v || out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        o_out_valid     = r_ovalid;
        o_packet_id_out = r_oid;
        o_delivered     = r_odel;
        o_cause         = r_ocause;
        o_last          = r_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_timeout <= TIMEOUT_RESET;
            r_valid   <= '0;
            r_seen    <= '0;
            r_fin     <= '0;
            r_pend_v  <= 1'b0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_timeout <= i_cfg_wr_data;

            if (in_acc) begin
                r_idx    <= '0;
                r_hit    <= 1'b0;
                r_free_v <= 1'b0;
                r_pend_v <= 1'b0;
                r_cnt    <= '0;
            end

            if (step) begin
                if (!last_idx) r_idx <= r_idx + IW'(1);
                if (r_cmd == CMD_ADD) begin
                    if (!cur_valid && !r_free_v) begin
                        r_free_v <= 1'b1;
                        r_tgt    <= r_idx;
                    end
                    if (r_idx == '0 || earlier) begin
                        r_best_idx  <= r_idx;
                        r_best_time <= cur_time;
                        r_best_id   <= cur_id;
                    end
                end
                if (ack_ev) begin
                    r_fin[r_idx] <= 1'b1;
                    r_hit        <= 1'b1;
                end
                if (r_cmd == CMD_POLL && cur_valid) begin
                    if (busy && !cur_fin) r_seen[r_idx] <= 1'b1;
                    if (cur_fin || poll_ev) r_valid[r_idx] <= 1'b0;
                end
                // reports beyond the cap still free their entry, silently
                if (hit_emit && can_rep) begin
                    r_pend_v     <= 1'b1;
                    r_pend_id    <= cur_id;
                    r_pend_del   <= hit_del;
                    r_pend_cause <= hit_cause;
                    r_cnt        <= r_cnt + CNT_W'(1);
                end
            end

            if (r_state == ST_FIN && r_cmd == CMD_ADD) begin
                r_eid[add_tgt]   <= r_id;
                r_etime[add_tgt] <= r_now;
                r_valid[add_tgt] <= 1'b1;
                r_seen[add_tgt]  <= 1'b0;
                r_fin[add_tgt]   <= 1'b0;
                if (!r_free_v) begin
                    r_pend_v     <= 1'b1;
                    r_pend_id    <= r_best_id;
                    r_pend_del   <= 1'b0;
                    r_pend_cause <= CAUSE_EVICT;
                    r_cnt        <= CNT_W'(1);
                end
            end

            if (r_state == ST_FLUSH && n_state == ST_IDLE) r_pend_v <= 1'b0;

            if (out_load) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    // Item payload and output payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_id   <= i_packet_id;
            r_ack  <= i_is_ack;
            r_now  <= i_now_ms;
            r_mask <= i_awaiting_mask;
        end
        if (out_load) begin
            r_oid    <= r_pend_id;
            r_odel   <= r_pend_del;
            r_ocause <= r_pend_cause;
            r_olast  <= push_last;
        end
    end

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("report count beyond cap");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_pend_v)
        else $error("held report left behind at idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_ovalid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_WALK && r_idx == '0 && r_cnt == '0))
        else $error("walk did not start at entry zero");
`endif

endmodule
